/* src/wpea_pkg.sv */
// ----------------------------------------------------------------------------
// Windowed per-element averager package
// Shared constants, item kinds, register indexes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package wpea_pkg;

	localparam int MAX_ELEMENTS = 1024;
	localparam int MAX_COLUMNS  = 8;
	localparam int DEPTH        = MAX_ELEMENTS * MAX_COLUMNS;
	localparam int ADDR_W       = $clog2(DEPTH);

	localparam int ENTRY_W = 40;
	localparam int STEP_W  = 48;
	localparam int DVD_W   = 48;
	localparam int DVS_W   = 24;

	localparam int IN_TDATA_W  = 128;
	localparam int OUT_TDATA_W = 104;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [2:0] {
		KIND_START  = 3'd0,
		KIND_BEGIN  = 3'd1,
		KIND_SAMPLE = 3'd2,
		KIND_END    = 3'd3,
		KIND_READ   = 3'd4
	} kind_t;

	localparam logic [2:0] CFG_SPACING = 3'd0;
	localparam logic [2:0] CFG_REPEATS = 3'd1;
	localparam logic [2:0] CFG_PERIOD  = 3'd2;
	localparam logic [2:0] CFG_GSELECT = 3'd3;
	localparam logic [2:0] CFG_NELEM   = 3'd4;
	localparam logic [2:0] CFG_NCOL    = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BAD,
		ST_SDIV,
		ST_RMW,
		ST_CLR,
		ST_DRD,
		ST_DWT,
		ST_DDIV,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

/* src/wpea_div.sv */
// ----------------------------------------------------------------------------
// Shared restoring divider
// Unsigned divide, one quotient bit per cycle, with quotient and remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module wpea_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [wpea_pkg::DVD_W-1:0] dividend,
	input  wire logic [wpea_pkg::DVS_W-1:0] divisor,
	output logic                            done,
	output logic      [wpea_pkg::DVD_W-1:0] quot,
	output logic      [wpea_pkg::DVS_W-1:0] rem
);
	import wpea_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] q_q;
	logic [DVS_W-1:0] r_q;
	logic [DVS_W-1:0] d_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {r_q, q_q[DVD_W-1]};
		diff  = trial - {1'b0, d_q};
		ge    = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(DVD_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[DVD_W-2:0], ge};
			r_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

`default_nettype wire

/* src/wpea_store.sv */
// ----------------------------------------------------------------------------
// Entry store
// One write port and one registered read port over the sum entries.
// ----------------------------------------------------------------------------
`default_nettype none

module wpea_store (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [wpea_pkg::ADDR_W-1:0]  waddr,
	input  wire logic [wpea_pkg::ENTRY_W-1:0] wdata,
	input  wire logic [wpea_pkg::ADDR_W-1:0]  raddr,
	output logic      [wpea_pkg::ENTRY_W-1:0] rdata
);
	import wpea_pkg::*;

	logic [ENTRY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* src/windowed_per_element_averager_top.sv */
// ----------------------------------------------------------------------------
// Windowed per-element averager
// Scheduled block averaging of per-element sums kept in an on-chip store.
// ----------------------------------------------------------------------------
// A sample or a read goes through a read-modify-write of the store's single
// read port. A step begin that clears nothing, a step end that does not close
// a window and an unknown kind go straight to the result state. A start runs
// a divide for the schedule, then a clear of all 8192 entries. A step begin
// that opens a window clears the in-use entries at one per cycle. A step end
// that closes a window divides each in-use entry through the shared divider,
// one entry at a time. After reset the block clears all 8192 entries before
// it takes its first beat, and after each configuration write it checks the
// settings through the divider before it takes the next beat.
`default_nettype none

module windowed_per_element_averager_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// step_now, element_index, column_index, group_mask, sample_value, pad
	input  wire logic [wpea_pkg::IN_TDATA_W-1:0]    s_tdata,
	// kind
	input  wire logic [2:0]                         s_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// step_active, next_valid_step, repeats_done, window_finished,
	// entry_value, settings_bad, pad
	output logic      [wpea_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  wire logic                               cfg_we,
	input  wire logic [2:0]                         cfg_index,
	input  wire logic [wpea_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import wpea_pkg::*;

	logic [15:0] spacing_q;
	logic [8:0]  repeats_q;
	logic [23:0] period_q;
	logic [31:0] gsel_q;
	logic [10:0] nelem_q;
	logic [3:0]  ncol_q;

	logic [15:0] s_eff;
	logic [8:0]  r_eff;
	logic [23:0] p_eff;
	logic [10:0] ne_eff;
	logic [3:0]  nc_eff;
	logic        raw_bad;

	logic [24:0] back_q;
	logic [24:0] rs_q;
	logic        bad_q;
	logic        dirty_q;

	state_t state_q, state_d;

	logic [STEP_W-1:0] vs_q;
	logic [7:0]        ri_q;
	logic              samp_q;

	kind_t             kind_q;
	logic [STEP_W-1:0] t_q;
	logic [ADDR_W-1:0] addr_q;
	logic              inrange_q;
	logic              ghit_q;
	logic [31:0]       sv_q;
	logic              fin_q;
	logic [ENTRY_W-1:0] entry_q;
	logic              neg_q;
	logic              init_q;

	logic [10:0] swne_q;
	logic [3:0]  swnc_q;
	logic [10:0] se_q;
	logic [3:0]  sc_q;
	logic        sw_last;
	logic [ADDR_W-1:0] sweep_addr;

	logic              m_tvalid_q;
	logic              o_act_q;
	logic [STEP_W-1:0] o_vs_q;
	logic [7:0]        o_ri_q;
	logic              o_fin_q;
	logic [ENTRY_W-1:0] o_entry_q;
	logic              o_bad_q;

	kind_t             kind_in;
	logic [STEP_W-1:0] in_t;
	logic [9:0]        in_el;
	logic [2:0]        in_col;
	logic [31:0]       in_gm;
	logic [31:0]       in_sv;
	logic [ADDR_W-1:0] in_addr;
	logic              in_range;
	logic              in_eq;
	logic              last_rep;
	logic [8:0]        next_ri;

	logic out_free;
	logic can_take;
	logic acc;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [ENTRY_W-1:0] mem_rdata;

	logic              div_start;
	logic [DVD_W-1:0]  div_dvd;
	logic [DVS_W-1:0]  div_dvs;
	logic              div_done;
	logic [DVD_W-1:0]  div_quot;
	logic [DVS_W-1:0]  div_rem;

	logic [ENTRY_W-1:0] mag;
	logic [ENTRY_W-1:0] qv;

	logic signed [50:0] nv_a;
	logic signed [50:0] nv_b;
	logic signed [50:0] t_s;

	wpea_store u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	wpea_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_comb begin
		s_eff   = (spacing_q == 16'd0) ? 16'd1 : spacing_q;
		p_eff   = (period_q == 24'd0) ? 24'd1 : period_q;
		if (repeats_q == 9'd0) begin
			r_eff = 9'd1;
		end else if (repeats_q > 9'd256) begin
			r_eff = 9'd256;
		end else begin
			r_eff = repeats_q;
		end
		ne_eff  = (nelem_q > 11'(MAX_ELEMENTS)) ? 11'(MAX_ELEMENTS) : nelem_q;
		nc_eff  = (ncol_q > 4'(MAX_COLUMNS)) ? 4'(MAX_COLUMNS) : ncol_q;
		raw_bad = (spacing_q == 16'd0) || (period_q == 24'd0) || (repeats_q == 9'd0)
			|| (repeats_q > 9'd256);
	end

	always_comb begin
		kind_in  = kind_t'(s_tuser);
		in_t     = s_tdata[47:0];
		in_el    = s_tdata[57:48];
		in_col   = s_tdata[60:58];
		in_gm    = s_tdata[92:61];
		in_sv    = s_tdata[124:93];
		in_addr  = ADDR_W'(in_el * MAX_COLUMNS + in_col);
		in_range = ({1'b0, in_el} < ne_eff) && ({1'b0, in_col} < nc_eff);
		in_eq    = in_t == vs_q;
		next_ri  = {1'b0, ri_q} + 9'd1;
		last_rep = next_ri >= r_eff;
		sweep_addr = ADDR_W'(se_q * MAX_COLUMNS + sc_q);
		sw_last  = (sc_q == swnc_q - 4'd1) && (se_q == swne_q - 11'd1);
		mag      = mem_rdata[ENTRY_W-1] ? (~mem_rdata + ENTRY_W'(1)) : mem_rdata;
		qv       = div_quot[ENTRY_W-1:0];
	end

	always_comb begin
		t_s  = $signed({3'b0, t_q});
		nv_a = t_s - $signed({27'b0, div_rem}) + $signed({27'b0, p_eff});
		if ((div_rem == '0) && (r_eff == 9'd1)) begin
			nv_b = t_s;
		end else begin
			nv_b = nv_a - $signed({26'b0, back_q});
		end
		if (nv_b < t_s) begin
			nv_b = nv_b + $signed({27'b0, p_eff});
		end
	end

	// Handshake and datapath control.
	always_comb begin
		out_free  = !m_tvalid_q || m_tready;
		can_take  = ((state_q == ST_IDLE) || ((state_q == ST_EMIT) && out_free)) && !dirty_q;
		s_tready  = can_take;
		acc       = s_tvalid && can_take;
		mem_we    = 1'b0;
		mem_waddr = sweep_addr;
		mem_wdata = '0;
		mem_raddr = in_addr;
		div_start = 1'b0;
		div_dvd   = DVD_W'(p_eff);
		div_dvs   = DVS_W'(s_eff);
		unique case (state_q)
			ST_IDLE: begin
				if (dirty_q) begin
					div_start = 1'b1;
				end else if (acc && (kind_in == KIND_START)) begin
					div_start = 1'b1;
					div_dvd   = in_t;
					div_dvs   = p_eff;
				end
			end
			ST_EMIT: begin
				if (acc && (kind_in == KIND_START)) begin
					div_start = 1'b1;
					div_dvd   = in_t;
					div_dvs   = p_eff;
				end
			end
			ST_RMW: begin
				mem_waddr = addr_q;
				mem_wdata = mem_rdata + {{(ENTRY_W-32){sv_q[31]}}, sv_q};
				mem_we    = (kind_q == KIND_SAMPLE) && samp_q && ghit_q && inrange_q;
			end
			ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_DRD: begin
				mem_raddr = sweep_addr;
			end
			ST_DWT: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(mag);
				div_dvs   = DVS_W'(r_eff);
			end
			ST_DDIV: begin
				mem_we    = div_done;
				mem_wdata = neg_q ? (~qv + ENTRY_W'(1)) : qv;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE, ST_EMIT: begin
				if (acc) begin
					unique case (kind_in)
						KIND_START: state_d = ST_SDIV;
						KIND_BEGIN: begin
							if (in_eq && (ri_q == 8'd0) && (ne_eff != 11'd0)
								&& (nc_eff != 4'd0)) begin
								state_d = ST_CLR;
							end else begin
								state_d = ST_EMIT;
							end
						end
						KIND_SAMPLE, KIND_READ: state_d = ST_RMW;
						KIND_END: begin
							if (in_eq && last_rep && (ne_eff != 11'd0) && (nc_eff != 4'd0)) begin
								state_d = ST_DRD;
							end else begin
								state_d = ST_EMIT;
							end
						end
						default: state_d = ST_EMIT;
					endcase
				end else if (state_q == ST_IDLE) begin
					if (dirty_q) begin
						state_d = ST_BAD;
					end
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_BAD: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_SDIV: begin
				if (div_done) begin
					state_d = ST_CLR;
				end
			end
			ST_RMW: state_d = ST_EMIT;
			ST_CLR: begin
				if (sw_last) begin
					state_d = init_q ? ST_IDLE : ST_EMIT;
				end
			end
			ST_DRD: state_d = ST_DWT;
			ST_DWT: state_d = ST_DDIV;
			ST_DDIV: begin
				if (div_done) begin
					state_d = sw_last ? ST_EMIT : ST_DRD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			init_q    <= 1'b1;
			swne_q    <= 11'(MAX_ELEMENTS);
			swnc_q    <= 4'(MAX_COLUMNS);
			se_q      <= '0;
			sc_q      <= '0;
			spacing_q <= 16'd1;
			repeats_q <= 9'd1;
			period_q  <= 24'd1;
			gsel_q    <= 32'hFFFF_FFFF;
			nelem_q   <= 11'd0;
			ncol_q    <= 4'd1;
			dirty_q   <= 1'b0;
			bad_q     <= 1'b0;
			vs_q      <= '0;
			ri_q      <= '0;
			samp_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				dirty_q <= 1'b1;
				unique case (cfg_index)
					CFG_SPACING: spacing_q <= cfg_data[15:0];
					CFG_REPEATS: repeats_q <= cfg_data[8:0];
					CFG_PERIOD:  period_q  <= cfg_data[23:0];
					CFG_GSELECT: gsel_q    <= cfg_data;
					CFG_NELEM:   nelem_q   <= cfg_data[10:0];
					CFG_NCOL:    ncol_q    <= cfg_data[3:0];
					default: begin
					end
				endcase
			end else if ((state_q == ST_IDLE) && dirty_q) begin
				dirty_q <= 1'b0;
			end

			if ((state_q == ST_BAD) && div_done) begin
				bad_q <= raw_bad || (div_rem != '0) || (rs_q > {1'b0, p_eff});
			end

			if (acc) begin
				se_q <= '0;
				sc_q <= '0;
				unique case (kind_in)
					KIND_START: begin
						ri_q   <= '0;
						samp_q <= 1'b0;
					end
					KIND_BEGIN: begin
						samp_q <= in_eq;
						swne_q <= ne_eff;
						swnc_q <= nc_eff;
					end
					KIND_END: begin
						samp_q <= 1'b0;
						swne_q <= ne_eff;
						swnc_q <= nc_eff;
						if (in_eq) begin
							if (!last_rep) begin
								ri_q <= next_ri[7:0];
								vs_q <= vs_q + STEP_W'(s_eff);
							end else begin
								ri_q <= '0;
								vs_q <= STEP_W'({1'b0, in_t} + 49'(p_eff) - 49'(back_q));
							end
						end
					end
					default: begin
					end
				endcase
			end

			if ((state_q == ST_SDIV) && div_done) begin
				vs_q   <= nv_b[STEP_W-1:0];
				swne_q <= 11'(MAX_ELEMENTS);
				swnc_q <= 4'(MAX_COLUMNS);
			end

			if ((state_q == ST_CLR) || ((state_q == ST_DDIV) && div_done)) begin
				if (sc_q == swnc_q - 4'd1) begin
					sc_q <= '0;
					se_q <= se_q + 11'd1;
				end else begin
					sc_q <= sc_q + 4'd1;
				end
				if ((state_q == ST_CLR) && sw_last) begin
					init_q <= 1'b0;
				end
			end

			if ((state_q == ST_EMIT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		back_q <= 25'((r_eff - 9'd1) * s_eff);
		rs_q   <= 25'(r_eff * s_eff);
		if (acc) begin
			kind_q    <= kind_in;
			t_q       <= in_t;
			addr_q    <= in_addr;
			inrange_q <= in_range;
			ghit_q    <= (in_gm & gsel_q) != 32'd0;
			sv_q      <= in_sv;
			fin_q     <= (kind_in == KIND_END) && in_eq && last_rep;
			entry_q   <= '0;
		end
		if ((state_q == ST_RMW) && (kind_q == KIND_READ) && inrange_q) begin
			entry_q <= mem_rdata;
		end
		if (state_q == ST_DWT) begin
			neg_q <= mem_rdata[ENTRY_W-1];
		end
		if ((state_q == ST_EMIT) && out_free) begin
			o_act_q   <= samp_q;
			o_vs_q    <= vs_q;
			o_ri_q    <= ri_q;
			o_fin_q   <= fin_q;
			o_entry_q <= entry_q;
			o_bad_q   <= bad_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, o_bad_q, o_entry_q, o_fin_q, o_ri_q, o_vs_q, o_act_q};

endmodule

`default_nettype wire

/* src/wpea_checker.sv */
// ----------------------------------------------------------------------------
// Windowed per-element averager port checker
// Watches the result stream of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

module wpea_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [103:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result beat dropped while stalled.");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("Result beat changed while stalled.");

	a_fin_repeats: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[57] |-> (m_tdata[56:49] == 8'd0))
		else $error("A finished window left a nonzero repeat count.");

	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[57] |-> !m_tdata[0])
		else $error("A finished window left the step marked active.");

endmodule

bind windowed_per_element_averager_top wpea_checker u_wpea_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
